### hw/rtl/ccc_pkg.sv
// Shared types and constants of the coast cell counter.
package ccc_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 21;

    localparam logic [CHAR_W-1:0]  LAND_CHAR = 8'h23;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Classification of one cell, produced by the front end.
    typedef struct packed {
        logic first_col;
        logic last_col;
        logic last_row;
        logic row_ge1;
        logic row_ge2;
        logic land;
    } item_flags_t;

    // One line store word: land flags of the two rows above the current one.
    typedef struct packed {
        logic above;
        logic middle;
    } cell_bits_t;

endpackage

### hw/rtl/ccc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/ccc_queue.sv
// Short queue between the front end and the back end.
module ccc_queue #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0]       mem_reg [ccc_pkg::Q_DEPTH];
    logic [ccc_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [ccc_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [ccc_pkg::Q_PTR_W:0]   count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign full    = (count_reg == (ccc_pkg::Q_PTR_W + 1)'(ccc_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (ccc_pkg::Q_PTR_W + 1)'(ccc_pkg::Q_DEPTH))
        else $error("queue count above depth");
    a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> rd_ptr_reg == $past(rd_ptr_reg) + 1'b1)
        else $error("pop did not advance read pointer");
`endif

endmodule

### hw/rtl/ccc_front.sv
// Front end: accepts cells, tracks the raster position and classifies each cell.
module ccc_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          push,
    output logic                                          full,
    input  logic [ccc_pkg::CHAR_W-1:0]                    cell_char,
    input  logic [ccc_pkg::CFG_W-1:0]                     num_rows,
    input  logic [ccc_pkg::CFG_W-1:0]                     num_cols,
    input  logic                                          clr_busy,
    input  logic                                          q_full,
    output logic                                          q_push,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] q_col,
    output ccc_pkg::item_flags_t                          q_flags
);

    localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CLW = ($clog2(MAX_COLS + 1) > ccc_pkg::CFG_W) ?
                         $clog2(MAX_COLS + 1) : ccc_pkg::CFG_W;
    localparam int RLW = ($clog2(MAX_ROWS + 1) > ccc_pkg::CFG_W) ?
                         $clog2(MAX_ROWS + 1) : ccc_pkg::CFG_W;

    logic [AW-1:0]  col_reg;
    logic [AW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;
    logic [CLW-1:0] cols_lim;
    logic [RLW-1:0] rows_lim;
    logic           accept;
    logic           last_col;
    logic           last_row;

    // Out-of-range sizes: zero acts as one, oversize acts as the maximum.
    always_comb
    begin
        if (num_cols == '0)
        begin
            cols_lim = CLW'(1);
        end
        else if (CLW'(num_cols) > CLW'(MAX_COLS))
        begin
            cols_lim = CLW'(MAX_COLS);
        end
        else
        begin
            cols_lim = CLW'(num_cols);
        end

        if (num_rows == '0)
        begin
            rows_lim = RLW'(1);
        end
        else if (RLW'(num_rows) > RLW'(MAX_ROWS))
        begin
            rows_lim = RLW'(MAX_ROWS);
        end
        else
        begin
            rows_lim = RLW'(num_rows);
        end
    end

    assign last_col = (CLW'(col_reg) + CLW'(1)) >= cols_lim;
    assign last_row = (RLW'(row_reg) + RLW'(1)) >= rows_lim;

    assign full   = q_full || clr_busy;
    assign accept = push && !full;
    assign q_push = accept;
    assign q_col  = col_reg;

    always_comb
    begin
        q_flags.first_col = (col_reg == '0);
        q_flags.last_col  = last_col;
        q_flags.last_row  = last_row;
        q_flags.row_ge1   = (row_reg != '0);
        q_flags.row_ge2   = (row_reg > RW'(1));
        q_flags.land      = (cell_char == ccc_pkg::LAND_CHAR);

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### hw/rtl/ccc_back.sv
// Back end: line store, neighbour judgment, coast count and result register.
module ccc_back #(
    parameter int MAX_COLS = 1024
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          q_empty,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] q_col,
    input  ccc_pkg::item_flags_t                          q_flags,
    output logic                                          q_pop,
    output logic                                          clr_busy,
    input  logic                                          pop,
    output logic                                          empty,
    output logic [ccc_pkg::COUNT_W-1:0]                   coast_count
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic                         b_valid_reg;
    logic [AW-1:0]                b_col_reg;
    ccc_pkg::item_flags_t         b_flags_reg;

    logic                         byp_reg;
    ccc_pkg::cell_bits_t          byp_bits_reg;
    ccc_pkg::cell_bits_t          rd_bits;
    ccc_pkg::cell_bits_t          cell_bits;
    ccc_pkg::cell_bits_t          wr_bits;

    logic                         clr_busy_reg;
    logic [AW-1:0]                clr_addr_reg;

    logic                         p_valid_reg;
    logic                         p_ge1_reg;
    logic                         p_up_reg;
    logic                         p_left_reg;
    logic                         p_centre_reg;
    logic                         p_cur_reg;

    logic [ccc_pkg::COUNT_W-1:0]  total_reg;
    logic [ccc_pkg::COUNT_W-1:0]  total_sat;
    logic [ccc_pkg::COUNT_W:0]    total_sum;
    logic                         res_valid_reg;
    logic [ccc_pkg::COUNT_W-1:0]  res_count_reg;

    logic                         centre;
    logic                         up;
    logic                         left;
    logic                         emit;
    logic                         b_done;
    logic                         b_adv;
    logic                         judge_prev;
    logic                         judge_cur;
    logic                         bottom_land;
    logic [1:0]                   inc;
    logic                         ram_wr_en;
    logic [AW-1:0]                ram_wr_addr;
    ccc_pkg::cell_bits_t          ram_wr_data;

    ccc_ram #(
        .WIDTH ($bits(ccc_pkg::cell_bits_t)),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (q_pop),
        .rd_addr (q_col),
        .rd_data (rd_bits)
    );

    always_comb
    begin
        // A write to the address being read in the same cycle is forwarded.
        cell_bits = byp_reg ? byp_bits_reg : rd_bits;
        centre    = cell_bits.middle;
        up        = b_flags_reg.row_ge2 && cell_bits.above;
        left      = !b_flags_reg.first_col && p_centre_reg;
        emit      = b_flags_reg.last_col && b_flags_reg.last_row;

        b_done = b_valid_reg && (!emit || !res_valid_reg || pop);
        b_adv  = !b_valid_reg || b_done;
        q_pop  = !q_empty && b_adv && !clr_busy_reg;

        // The cell one step back is judged once its right neighbour is known.
        judge_prev = p_valid_reg && p_ge1_reg && p_centre_reg &&
                     !(p_up_reg && p_left_reg && centre && p_cur_reg);
        // In the last column the right neighbour is water, so a land cell is coast.
        judge_cur   = b_flags_reg.last_col && b_flags_reg.row_ge1 && centre;
        bottom_land = b_flags_reg.last_row && b_flags_reg.land;

        inc = 2'(judge_prev) + 2'(judge_cur) + 2'(bottom_land);
        total_sum = {1'b0, total_reg} + (ccc_pkg::COUNT_W + 1)'(inc);
        total_sat = (total_sum > {1'b0, ccc_pkg::COUNT_MAX}) ?
                    ccc_pkg::COUNT_MAX : total_sum[ccc_pkg::COUNT_W-1:0];

        wr_bits.above  = centre;
        wr_bits.middle = b_flags_reg.land;

        ram_wr_en   = clr_busy_reg || b_done;
        ram_wr_addr = clr_busy_reg ? clr_addr_reg : b_col_reg;
        ram_wr_data = clr_busy_reg ? '0 : wr_bits;
    end

    assign clr_busy    = clr_busy_reg;
    assign empty       = !res_valid_reg;
    assign coast_count = res_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            b_valid_reg   <= 1'b0;
            byp_reg       <= 1'b0;
            p_valid_reg   <= 1'b0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MAX_COLS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (b_adv)
            begin
                b_valid_reg <= q_pop;
            end
            if (q_pop)
            begin
                byp_reg <= b_done && (b_col_reg == q_col);
            end

            if (b_done)
            begin
                p_valid_reg <= !b_flags_reg.last_col;
                total_reg   <= emit ? '0 : total_sat;
            end

            if (b_done && emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_col_reg    <= q_col;
            b_flags_reg  <= q_flags;
            byp_bits_reg <= wr_bits;
        end
        if (b_done)
        begin
            p_ge1_reg    <= b_flags_reg.row_ge1;
            p_up_reg     <= up;
            p_left_reg   <= left;
            p_centre_reg <= centre;
            p_cur_reg    <= b_flags_reg.land;
        end
        if (b_done && emit)
        begin
            res_count_reg <= total_sat;
        end
    end

`ifndef SYNTHESIS
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !b_valid_reg && !q_pop)
        else $error("cell processed during line store clear");
    a_row_start_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_flags_reg.first_col |-> !p_valid_reg)
        else $error("pending cell carried across a row boundary");
    a_emit_sets_result: assert property (@(posedge clk) disable iff (!rst_n)
        b_done && emit |=> res_valid_reg && total_reg == '0)
        else $error("frame end did not post a result");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !pop |=> res_valid_reg && $stable(res_count_reg))
        else $error("waiting result lost or changed");
`endif

endmodule

### hw/rtl/coast_cell_counter.sv
// Coast cell counter: counts land cells with a water four-neighbour per map frame.
//
// Usage: map cells enter one per transfer on the input queue (push/full,
// cell_char) in raster order, num_cols cells per row and num_rows rows per
// frame; '#' is land. After the last cell of a frame one result, the frame's
// coast count, appears on the output queue (empty/pop, coast_count).
// num_rows (index 0) and num_cols (index 1) are written through cfg_wr_en,
// cfg_index and cfg_data; they reset to 1 and are changed between transfers.
// Throughput is one cell per cycle while full is low: the line store RAM is read once and
// written once per cell, with a one-cell delay for the right neighbour.
// A frame's last cell passes the queue and the back end stage; then empty falls.
// A waiting result does not block input; when the result register is held
// by a stalled receiver, the next frame end stalls the back end, the
// two-entry queue fills and full rises until the result is popped.
// After reset all MAX_COLS line store words are cleared with full high;
// configuration writes are taken during that time.
module coast_cell_counter #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [ccc_pkg::CHAR_W-1:0]        cell_char,
    output logic                              empty,
    input  logic                              pop,
    output logic [ccc_pkg::COUNT_W-1:0]       coast_count,
    input  logic                              cfg_wr_en,
    input  logic [ccc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccc_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int QW = AW + $bits(ccc_pkg::item_flags_t);

    logic [ccc_pkg::CFG_W-1:0] num_rows_reg;
    logic [ccc_pkg::CFG_W-1:0] num_cols_reg;

    logic                      clr_busy;
    logic                      q_full;
    logic                      q_push;
    logic [AW-1:0]             f_col;
    ccc_pkg::item_flags_t      f_flags;
    logic                      q_pop;
    logic                      q_empty;
    logic [QW-1:0]             q_head;
    logic [AW-1:0]             b_col;
    ccc_pkg::item_flags_t      b_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= ccc_pkg::CFG_W'(1);
            num_cols_reg <= ccc_pkg::CFG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ccc_pkg::REG_NUM_ROWS: num_rows_reg <= cfg_data;
                ccc_pkg::REG_NUM_COLS: num_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ccc_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cell_char (cell_char),
        .num_rows  (num_rows_reg),
        .num_cols  (num_cols_reg),
        .clr_busy  (clr_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_col     (f_col),
        .q_flags   (f_flags)
    );

    ccc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data ({f_col, f_flags}),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    assign b_col   = q_head[QW-1 -: AW];
    assign b_flags = q_head[$bits(ccc_pkg::item_flags_t)-1:0];

    ccc_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_col       (b_col),
        .q_flags     (b_flags),
        .q_pop       (q_pop),
        .clr_busy    (clr_busy),
        .pop         (pop),
        .empty       (empty),
        .coast_count (coast_count)
    );

endmodule

### dv/testbench.sv
// Self-checking testbench for the coast cell counter: raster map cells in, frame coast counts out.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_CELLS = 340;
    localparam int MIN_FRAMES   = 40;
    localparam int SCRIPT_LEN   = 27;
    localparam int WIDE_LEN     = 4;

    typedef enum bit {STEP_CELL, STEP_RESIZE} step_kind_t;

    typedef struct packed {
        step_kind_t                   kind;
        logic [ccc_pkg::CFG_W-1:0]    rows;
        logic [ccc_pkg::CFG_W-1:0]    cols;
        logic [ccc_pkg::CHAR_W-1:0]   ch;
        bit                           typed;
        logic [ccc_pkg::COUNT_W-1:0]  count;
    } script_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic [ccc_pkg::CHAR_W-1:0]    cell_char;
    logic                          empty;
    logic                          pop;
    logic [ccc_pkg::COUNT_W-1:0]   coast_count;
    logic                          cfg_wr_en;
    logic [ccc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ccc_pkg::CFG_W-1:0]     cfg_data;

    // Predictor state: size registers, the two line stores and the scan position.
    logic [ccc_pkg::CFG_W-1:0]     size_rows = 11'd1;
    logic [ccc_pkg::CFG_W-1:0]     size_cols = 11'd1;
    bit                            line_two_up [MAX_COLS];
    bit                            line_one_up [MAX_COLS];
    logic [2:0]                    neighbor_window = '0;
    int unsigned                   scan_col = 0;
    int unsigned                   scan_row = 0;
    logic [ccc_pkg::COUNT_W-1:0]   coast_running = '0;

    logic [ccc_pkg::COUNT_W-1:0]   pending_counts [$];
    logic [ccc_pkg::COUNT_W-1:0]   want;
    bit                            no_idle = 1'b0;
    bit                            hold_request = 1'b0;
    int                            error_count = 0;
    int                            frames_checked = 0;
    int                            frames_predicted = 0;
    int                            cells_sent = 0;
    int                            stall_cycles = 0;
    int                            size_writes = 0;
    int                            long_holds = 0;

    // Directed script: 1x1 frames first (each cell is its own frame), then small maps.
    script_row_t script [SCRIPT_LEN] = '{
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b1, 21'd1},
        '{STEP_CELL,   11'd0, 11'd0, 8'h00,              1'b1, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, 8'hFF,              1'b1, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, 8'hA3,              1'b1, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, 8'h22,              1'b1, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, 8'hDC,              1'b1, 21'd0},
        '{STEP_RESIZE, 11'd3, 11'd3, 8'h00,              1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b1, 21'd8},
        '{STEP_RESIZE, 11'd0, 11'd0, 8'h00,              1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b1, 21'd1},
        '{STEP_RESIZE, 11'd1, 11'd3, 8'h00,              1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, 8'h2E,              1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b1, 21'd2},
        '{STEP_RESIZE, 11'd2, 11'd2, 8'h00,              1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, ccc_pkg::LAND_CHAR, 1'b0, 21'd0},
        '{STEP_CELL,   11'd0, 11'd0, 8'h2E,              1'b1, 21'd3}
    };

    // Oversized shapes are entered for a few cells only; the next phase writes both
    // sizes anew, so the open frame closes at the new last row and column.
    logic [ccc_pkg::CFG_W-1:0] wide_rows [WIDE_LEN] = '{11'd2,    11'd1,    11'd2047, 11'd1024};
    logic [ccc_pkg::CFG_W-1:0] wide_cols [WIDE_LEN] = '{11'd1024, 11'd2047, 11'd0,    11'd1};

    coast_cell_counter #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .cell_char(cell_char),
        .empty(empty),
        .pop(pop),
        .coast_count(coast_count),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned effective(input logic [ccc_pkg::CFG_W-1:0] v,
                                              input int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return 32'(v);
    endfunction

    // Advances the map scan by one cell and returns the frame count when the frame closes.
    function automatic void advance_map(input logic [ccc_pkg::CHAR_W-1:0] ch,
                                        output bit done,
                                        output logic [ccc_pkg::COUNT_W-1:0] count);
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned c;
        int unsigned r;
        bit          last_col;
        bit          last_row;
        bit          land;
        bit          left;
        bit          centre;
        bit          right;
        bit          up;
        bit          hits [2];
        rows_eff = effective(size_rows, MAX_ROWS);
        cols_eff = effective(size_cols, MAX_COLS);
        c        = scan_col;
        r        = scan_row;
        last_col = c >= cols_eff - 1;
        last_row = r >= rows_eff - 1;
        land     = ch == ccc_pkg::LAND_CHAR;
        done     = 1'b0;
        count    = '0;
        if (c >= MAX_COLS)
            c = MAX_COLS - 1;
        centre = line_one_up[c];
        right  = (last_col || c + 1 >= MAX_COLS) ? 1'b0 : line_one_up[c + 1];
        left   = (c == 0) ? 1'b0 : neighbor_window[1];
        up     = (r >= 2) ? line_two_up[c] : 1'b0;
        // The cell above is judged now that its lower neighbor is known; land in
        // the last row always borders the outside.
        hits[0] = r >= 1 && centre && !(up && left && right && land);
        hits[1] = last_row && land;
        foreach (hits[i])
            if (hits[i] && coast_running != ccc_pkg::COUNT_MAX)
                coast_running++;
        neighbor_window = {left, centre, right};
        line_two_up[c]  = centre;
        line_one_up[c]  = land;
        if (!last_col)
        begin
            scan_col = c + 1;
            return;
        end
        scan_col        = 0;
        neighbor_window = '0;
        if (!last_row)
        begin
            scan_row = r + 1;
            return;
        end
        done          = 1'b1;
        count         = coast_running;
        coast_running = '0;
        scan_row      = 0;
    endfunction

    function automatic int unsigned cells_to_frame_end();
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned in_row;
        rows_eff = effective(size_rows, MAX_ROWS);
        cols_eff = effective(size_cols, MAX_COLS);
        in_row   = (scan_col >= cols_eff - 1) ? 1 : cols_eff - scan_col;
        if (scan_row >= rows_eff - 1)
            return in_row;
        return in_row + (rows_eff - 1 - scan_row) * cols_eff;
    endfunction

    function automatic logic [ccc_pkg::CHAR_W-1:0] map_char(input int land_pct);
        if ($urandom_range(1, 100) <= land_pct)
            return ccc_pkg::LAND_CHAR;
        return ccc_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic send_cell(input logic [ccc_pkg::CHAR_W-1:0] ch, input bit typed,
                             input logic [ccc_pkg::COUNT_W-1:0] typed_count);
        int                          gap;
        bit                          done;
        logic [ccc_pkg::COUNT_W-1:0] count;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        cell_char <= ch;
        do
        begin
            @(posedge clk);
            if (full)
                stall_cycles++;
        end while (full);
        advance_map(ch, done, count);
        cells_sent++;
        if (done)
        begin
            pending_counts.push_back(typed ? typed_count : count);
            frames_predicted++;
        end
    endtask

    // Holds the input until every frame count has been taken and the pipeline is empty.
    task automatic settle();
        push <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(input bit do_rows, input bit do_cols,
                               input logic [ccc_pkg::CFG_W-1:0] rows_v,
                               input logic [ccc_pkg::CFG_W-1:0] cols_v);
        if (do_rows)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ccc_pkg::REG_NUM_ROWS;
            cfg_data  <= rows_v;
            @(posedge clk);
            size_rows = rows_v;
            size_writes++;
        end
        if (do_cols)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ccc_pkg::REG_NUM_COLS;
            cfg_data  <= cols_v;
            @(posedge clk);
            size_cols = cols_v;
            size_writes++;
        end
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_counts.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("coast_count %0d delivered with no frame pending", coast_count);
            end
            else
            begin
                want = pending_counts.pop_front();
                frames_checked++;
                if (coast_count !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("frame %0d: coast_count expected %0d, got %0d",
                                 frames_checked, want, coast_count);
                end
            end
        end
    end

    // Result side: random stalls per transfer, plus one long hold-off on request.
    initial
    begin
        int gap;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                long_holds++;
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
            begin
                @(posedge clk);
            end while (empty);
        end
    end

    initial
    begin
        int                        phase;
        int                        wide_idx;
        int                        which;
        int                        land_pct;
        int unsigned               remaining;
        int unsigned               n;
        int unsigned               random_cells;
        logic [ccc_pkg::CFG_W-1:0] new_rows;
        logic [ccc_pkg::CFG_W-1:0] new_cols;
        bit                        wide;
        bit                        force_both;
        phase        = 0;
        wide_idx     = 0;
        random_cells = 0;
        force_both   = 1'b0;
        push      <= 1'b0;
        cell_char <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= ccc_pkg::REG_NUM_ROWS;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == STEP_RESIZE)
            begin
                settle();
                write_sizes(1'b1, 1'b1, script[i].rows, script[i].cols);
            end
            else
                send_cell(script[i].ch, script[i].typed, script[i].count);
        end

        while (random_cells < RANDOM_CELLS || frames_predicted < MIN_FRAMES ||
               wide_idx < WIDE_LEN)
        begin
            settle();
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 8)
            begin
                // Stall the result side while 1x1 frames keep coming, so the block backs up.
                write_sizes(1'b1, 1'b1, 11'd1, 11'd1);
                no_idle      = 1'b1;
                hold_request = 1'b1;
                repeat (24) send_cell(map_char(50), 1'b0, '0);
            end
            else
            begin
                wide = (phase % 2 == 1) && wide_idx < WIDE_LEN;
                if (wide)
                begin
                    new_rows   = wide_rows[wide_idx];
                    new_cols   = wide_cols[wide_idx];
                    which      = 2;
                    force_both = 1'b1;
                    wide_idx++;
                end
                else
                begin
                    new_rows = ($urandom_range(0, 9) == 0) ? 11'd0 :
                               ccc_pkg::CFG_W'($urandom_range(1, 6));
                    new_cols = ($urandom_range(0, 9) == 0) ? 11'd0 :
                               ccc_pkg::CFG_W'($urandom_range(1, 8));
                    which      = force_both ? 2 : $urandom_range(0, 2);
                    force_both = 1'b0;
                end
                write_sizes(which != 1, which != 0, new_rows, new_cols);
                land_pct  = 25 * $urandom_range(0, 4);
                remaining = cells_to_frame_end();
                // Some phases stop inside a frame, so the next size change lands mid-frame.
                if (wide)
                    n = $urandom_range(1, 6);
                else if ($urandom_range(0, 3) == 0 && remaining > 1)
                    n = $urandom_range(1, remaining - 1);
                else
                    n = remaining + $urandom_range(0, 3) *
                        effective(size_rows, MAX_ROWS) * effective(size_cols, MAX_COLS);
                repeat (n) send_cell(map_char(land_pct), 1'b0, '0);
                if (!wide)
                    random_cells += n;
            end
            phase++;
        end

        settle();
        @(negedge clk);
        $display("Sent %0d map cells over %0d phases with %0d size writes;",
                 cells_sent, phase, size_writes);
        $display("%0d frame counts checked, input held off for %0d cycles, %0d long hold-off(s).",
                 frames_checked, stall_cycles, long_holds);
        if (error_count == 0 && pending_counts.size() == 0)
            $display("coast_cell_counter: match");
        else
            $display("coast_cell_counter: mismatch");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Timed out with %0d frame counts outstanding.", pending_counts.size());
        $display("coast_cell_counter: mismatch");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ccc_pkg.sv
hw/rtl/ccc_ram.sv
hw/rtl/ccc_queue.sv
hw/rtl/ccc_front.sv
hw/rtl/ccc_back.sv
hw/rtl/coast_cell_counter.sv
dv/testbench.sv
